// File: design/pip_pkg.sv
// Shared constants for the point-in-parallelogram test: default widths,
// configuration register indexes and result region codes.
// No dependencies.
package pip_pkg;

	// Default coordinate format, signed Q16.16
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// Tolerance register width (unsigned, same units as the coordinate fraction)
	localparam int TOL_W = 16;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE1_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE1_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE2_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE2_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TOL     = 3'd6;

	// Region codes: which branch of the test decided
	localparam int REGION_W = 3;
	localparam logic [REGION_W-1:0] REGION_FREE    = 3'd0;
	localparam logic [REGION_W-1:0] REGION_STRIP2  = 3'd1;
	localparam logic [REGION_W-1:0] REGION_STRIP1  = 3'd2;
	localparam logic [REGION_W-1:0] REGION_DEGEN   = 3'd3;
	localparam logic [REGION_W-1:0] REGION_GENERAL = 3'd4;

	// Result stream width (inside flag + region code, padded to a byte)
	localparam int OUT_DW = 8;

	// Cycles for the frame terms to settle after a register write
	localparam int FRAME_LAT = 4;
	localparam int CNT_W     = 3;

endpackage

// File: design/point_in_parallelogram_test.sv
// Point-in-parallelogram test, top level: frame term precompute and the
// four-stage point pipeline with per-stage flow control.
// Depends on pip_pkg.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tdata: point_x, point_y
//  m_*      | out       | m_tvalid/m_tready  | m_tdata: inside_res, region_case
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (register write)
//
// One point per cycle sustained while m_tready is high and s_tready is not held low;
// m_tvalid for a point rises when it reaches the stage 4 register, after stages 1 to 3.
// The rate is set by the four-multiplier stage, one pass per point.
// After reset and any register write, s_tready stays low until a counter loaded
// with FRAME_LAT runs out, while the frame terms (squared lengths, determinant,
// thresholds) pass their own four-stage chain. Each stage holds its item when the
// stage after it is full and stalled; bubbles close up, nothing dropped or repeated.
module point_in_parallelogram_test import pip_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// point stream in
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,   // point_x, point_y
	// result stream out
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [OUT_DW-1:0]                      m_tdata,   // inside_res, region_case
	// register writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]                   cfg_index,
	input  logic [COORD_WIDTH-1:0]                 cfg_data
);

	localparam int W    = COORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int CW   = W + 1;          // difference / coefficient width
	localparam int PW   = 2 * W + 2;      // point product width
	localparam int NW   = 2 * W + 3;      // numerator width
	localparam int SQW  = 2 * W;          // frame product width
	localparam int QW   = 2 * W + 1;      // squared length / determinant width
	localparam int DW   = 2 * W;          // denominator width (unsigned)
	localparam int KW   = ((F > TOL_W) ? F : TOL_W) + 1;
	localparam int MAXA = ((NW + F) > (DW + KW)) ? (NW + F) : (DW + KW);
	localparam int CMPW = MAXA + 1;
	localparam logic [KW-1:0] ONE = KW'(1) << F;

	// ---------------------------------------------------------------
	// Configuration registers
	logic signed [W-1:0] base_x_q, base_y_q;
	logic signed [W-1:0] edge1_x_q, edge1_y_q, edge2_x_q, edge2_y_q;
	logic [TOL_W-1:0]    tol_q;
	logic [CNT_W-1:0]    settle_cnt_q;
	logic                cfg_fire;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q  <= '0;
			base_y_q  <= '0;
			edge1_x_q <= '0;
			edge1_y_q <= '0;
			edge2_x_q <= '0;
			edge2_y_q <= '0;
			tol_q     <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				REG_BASE_X:  base_x_q  <= cfg_data;
				REG_BASE_Y:  base_y_q  <= cfg_data;
				REG_EDGE1_X: edge1_x_q <= cfg_data;
				REG_EDGE1_Y: edge1_y_q <= cfg_data;
				REG_EDGE2_X: edge2_x_q <= cfg_data;
				REG_EDGE2_Y: edge2_y_q <= cfg_data;
				REG_TOL:     tol_q     <= cfg_data[TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Hold off points until the frame terms reflect the latest registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_cnt_q <= CNT_W'(FRAME_LAT);
		end else if (cfg_fire) begin
			settle_cnt_q <= CNT_W'(FRAME_LAT);
		end else if (settle_cnt_q != '0) begin
			settle_cnt_q <= settle_cnt_q - CNT_W'(1);
		end
	end

	// ---------------------------------------------------------------
	// Frame terms, stage 1: squares, cross terms, squared tolerance
	logic signed [CW-1:0] ax_w, ay_w, bx_w, by_w;
	logic signed [SQW-1:0] axx_q, ayy_q, bxx_q, byy_q, axby_q, aybx_q;
	logic [2*TOL_W-1:0]    tol2_q;

	assign ax_w = CW'(edge1_x_q);
	assign ay_w = CW'(edge1_y_q);
	assign bx_w = CW'(edge2_x_q);
	assign by_w = CW'(edge2_y_q);

	always_ff @(posedge clk) begin
		axx_q  <= edge1_x_q * edge1_x_q;
		ayy_q  <= edge1_y_q * edge1_y_q;
		bxx_q  <= edge2_x_q * edge2_x_q;
		byy_q  <= edge2_y_q * edge2_y_q;
		axby_q <= edge1_x_q * edge2_y_q;
		aybx_q <= edge1_y_q * edge2_x_q;
		tol2_q <= tol_q * tol_q;
	end

	// Frame terms, stage 2: squared lengths and determinant
	logic signed [QW-1:0] q1_q, q2_q, det_q;
	logic [2*TOL_W-1:0]   tol2_d_q;

	always_ff @(posedge clk) begin
		q1_q     <= QW'(axx_q) + QW'(ayy_q);
		q2_q     <= QW'(bxx_q) + QW'(byy_q);
		det_q    <= QW'(axby_q) - QW'(aybx_q);
		tol2_d_q <= tol2_q;
	end

	// Frame terms, stage 3: branch, denominator and point coefficients
	logic                 unb1, unb2, det_neg;
	logic signed [QW-1:0] tol2_ext, det_abs;
	logic [REGION_W-1:0]  region_d;
	logic [DW-1:0]        den_d;
	logic signed [CW-1:0] c0_d, c1_d, c2_d, c3_d;
	logic [REGION_W-1:0]  region_q;
	logic [DW-1:0]        den_q;
	logic signed [CW-1:0] c0_q, c1_q, c2_q, c3_q;

	assign tol2_ext = signed'(QW'(tol2_d_q));
	assign unb1     = q1_q <= tol2_ext;
	assign unb2     = q2_q <= tol2_ext;
	assign det_neg  = det_q[QW-1];
	assign det_abs  = det_neg ? -det_q : det_q;

	always_comb begin
		region_d = REGION_GENERAL;
		den_d    = DW'(det_abs);
		c0_d     = '0;
		c1_d     = '0;
		c2_d     = '0;
		c3_d     = '0;
		priority if (unb1 && unb2) begin
			region_d = REGION_FREE;
		end else if (unb1) begin
			// projection on edge2 over its squared length
			region_d = REGION_STRIP2;
			den_d    = DW'(q2_q);
			c0_d     = bx_w;
			c1_d     = by_w;
		end else if (unb2) begin
			region_d = REGION_STRIP1;
			den_d    = DW'(q1_q);
			c0_d     = ax_w;
			c1_d     = ay_w;
		end else if (det_q == '0) begin
			region_d = REGION_DEGEN;
		end else begin
			// sn = P x E2, tn = E1 x P, signs folded so that det > 0
			c0_d = det_neg ? -by_w : by_w;
			c1_d = det_neg ? bx_w : -bx_w;
			c2_d = det_neg ? ay_w : -ay_w;
			c3_d = det_neg ? -ax_w : ax_w;
		end
	end

	always_ff @(posedge clk) begin
		region_q <= region_d;
		den_q    <= den_d;
		c0_q     <= c0_d;
		c1_q     <= c1_d;
		c2_q     <= c2_d;
		c3_q     <= c3_d;
	end

	// Frame terms, stage 4: range thresholds, lower one already negated
	logic [KW-1:0]          khi;
	logic [DW+TOL_W-1:0]    lo_prod;
	logic [DW+KW-1:0]       hi_prod;
	logic signed [CMPW-1:0] lo_neg_q, hi_q;

	assign khi     = ONE + KW'(tol_q);
	assign lo_prod = (DW+TOL_W)'(den_q) * (DW+TOL_W)'(tol_q);
	assign hi_prod = (DW+KW)'(den_q) * (DW+KW)'(khi);

	always_ff @(posedge clk) begin
		lo_neg_q <= -signed'(CMPW'(lo_prod));
		hi_q     <= signed'(CMPW'(hi_prod));
	end

	// ---------------------------------------------------------------
	// Point pipeline flow control
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic in_fire;

	assign rdy4     = !v_s4 || m_tready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1 && (settle_cnt_q == '0);
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_fire;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Stage 1: offset from the base corner
	logic signed [W-1:0]  pt_x, pt_y;
	logic signed [CW-1:0] px_s1, py_s1;

	assign pt_x = s_tdata[W-1:0];
	assign pt_y = s_tdata[2*W-1:W];

	always_ff @(posedge clk) begin
		if (rdy1) begin
			px_s1 <= CW'(pt_x) - CW'(base_x_q);
			py_s1 <= CW'(pt_y) - CW'(base_y_q);
		end
	end

	// Stage 2: four products against the branch coefficients
	logic signed [PW-1:0] pa0_s2, pa1_s2, pb0_s2, pb1_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			pa0_s2 <= PW'(px_s1) * PW'(c0_q);
			pa1_s2 <= PW'(py_s1) * PW'(c1_q);
			pb0_s2 <= PW'(px_s1) * PW'(c2_q);
			pb1_s2 <= PW'(py_s1) * PW'(c3_q);
		end
	end

	// Stage 3: numerators
	logic signed [NW-1:0] num_a_s3, num_b_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			num_a_s3 <= NW'(pa0_s2) + NW'(pa1_s2);
			num_b_s3 <= NW'(pb0_s2) + NW'(pb1_s2);
		end
	end

	// Stage 4: range compares and verdict, also the output register
	logic signed [CMPW-1:0] nf_a, nf_b;
	logic                   ok_a, ok_b, inside_d;
	logic                   inside_s4;
	logic [REGION_W-1:0]    region_s4;

	assign nf_a = CMPW'(num_a_s3) <<< F;
	assign nf_b = CMPW'(num_b_s3) <<< F;
	assign ok_a = (nf_a >= lo_neg_q) && (nf_a <= hi_q);
	assign ok_b = (nf_b >= lo_neg_q) && (nf_b <= hi_q);

	always_comb begin
		unique case (region_q)
			REGION_FREE:  inside_d = 1'b1;
			REGION_DEGEN: inside_d = 1'b0;
			default:      inside_d = ok_a && ok_b;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			inside_s4 <= inside_d;
			region_s4 <= region_q;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {(OUT_DW-REGION_W-1)'(0), region_s4, inside_s4};

endmodule

// File: sim/pip_result_check.sv
`timescale 1ns / 100ps
// Result checker for the point-in-parallelogram test: tracks register writes,
// predicts inside flag and region code for every point transaction, and compares
// them with the result stream in order. Depends on pip_pkg.
module pip_result_check import pip_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [63:0]           s_tdata,   // point_x, point_y
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DW-1:0]     m_tdata,   // inside_res, region_case
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]           cfg_data,
	output int                    fails,
	output int                    pending
);

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic                hit;
		logic [REGION_W-1:0] region;
	} verdict_t;

	// local copy of the frame registers
	logic signed [31:0] org_x, org_y, span1_x, span1_y, span2_x, span2_y;
	logic [TOL_W-1:0]   slack;

	verdict_t verdict_q[$];
	int       results_seen;

	// num/den within [-slack, 1+slack], den > 0, no division
	function automatic logic in_band(input wide_t num, input wide_t den);
		wide_t tw, scaled, lo_lim, hi_lim;
		tw     = slack;
		scaled = num <<< FRAC_BITS_DEF;
		lo_lim = -(tw * den);
		hi_lim = ((wide_t'(1) <<< FRAC_BITS_DEF) + tw) * den;
		return (scaled >= lo_lim) && (scaled <= hi_lim);
	endfunction

	function automatic verdict_t classify_point(input logic signed [31:0] qx,
		input logic signed [31:0] qy);
		wide_t px, py, ax, ay, bx, by, tw, len1, len2, det, sn, tn;
		logic  free1, free2;
		verdict_t v;
		px = qx;
		py = qy;
		ax = span1_x;
		ay = span1_y;
		bx = span2_x;
		by = span2_y;
		tw = slack;
		px = px - wide_t'(org_x);
		py = py - wide_t'(org_y);
		len1  = ax * ax + ay * ay;
		len2  = bx * bx + by * by;
		free1 = (tw * tw) >= len1;
		free2 = (tw * tw) >= len2;
		if (free1 && free2) begin
			v.region = REGION_FREE;
			v.hit    = 1'b1;
		end else if (free1) begin
			v.region = REGION_STRIP2;
			v.hit    = in_band(px * bx + py * by, len2);
		end else if (free2) begin
			v.region = REGION_STRIP1;
			v.hit    = in_band(px * ax + py * ay, len1);
		end else begin
			det = ax * by - ay * bx;
			if (det == 0) begin
				v.region = REGION_DEGEN;
				v.hit    = 1'b0;
			end else begin
				sn = px * by - py * bx;
				tn = ax * py - ay * px;
				// normalize to a positive determinant
				if (det < 0) begin
					det = -det;
					sn  = -sn;
					tn  = -tn;
				end
				v.region = REGION_GENERAL;
				v.hit    = in_band(sn, det) && in_band(tn, det);
			end
		end
		return v;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%t result %0d: %s is %0d, expected %0d", $realtime, results_seen, what,
			got, want);
		fails++;
	endtask

	// watch all three channels
	always @(posedge clk) begin
		verdict_t got, want;
		if (!arst_n) begin
			org_x   <= '0;
			org_y   <= '0;
			span1_x <= '0;
			span1_y <= '0;
			span2_x <= '0;
			span2_y <= '0;
			slack   <= '0;
			verdict_q.delete();
			pending <= 0;
		end else begin
			// register write transaction
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BASE_X:  org_x   <= cfg_data;
					REG_BASE_Y:  org_y   <= cfg_data;
					REG_EDGE1_X: span1_x <= cfg_data;
					REG_EDGE1_Y: span1_y <= cfg_data;
					REG_EDGE2_X: span2_x <= cfg_data;
					REG_EDGE2_Y: span2_y <= cfg_data;
					REG_TOL:     slack   <= cfg_data[TOL_W-1:0];
					default: ;
				endcase
			end
			// point transaction
			if (s_tvalid && s_tready)
				verdict_q.push_back(classify_point(s_tdata[31:0], s_tdata[63:32]));
			// result transaction
			if (m_tvalid && m_tready) begin
				got.hit    = m_tdata[0];
				got.region = m_tdata[3:1];
				if (verdict_q.size() == 0) begin
					flag_mismatch("unexpected result, region", got.region, -1);
				end else begin
					want = verdict_q.pop_front();
					if (got.hit !== want.hit)
						flag_mismatch("inside_res", got.hit, want.hit);
					if (got.region !== want.region)
						flag_mismatch("region_case", got.region, want.region);
				end
				results_seen++;
			end
			pending <= verdict_q.size();
		end
	end

endmodule

// File: sim/point_in_parallelogram_test_tb.sv
`timescale 1ns / 100ps
// Testbench top for the point-in-parallelogram test: clock, reset, register
// writes, point stimulus and result-side pacing; checking is in pip_result_check.
// Depends on pip_pkg, point_in_parallelogram_test and pip_result_check.
module point_in_parallelogram_test_tb;
	import pip_pkg::*;

	localparam int ITEMS = 1350;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;   // unused index, must be ignored
	localparam longint ONE = 65536;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [63:0]          s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_DW-1:0]    m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	int   fails;
	int   pending;
	int   items_sent;
	int   burst_left;
	logic long_hold;

	// frame as last written, used to shape points
	longint fb_bx, fb_by, fb_e1x, fb_e1y, fb_e2x, fb_e2y, perp_x, perp_y;
	int     fb_tol;
	bit     wild_pts;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	point_in_parallelogram_test u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pip_result_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending)
	);

	function automatic logic [63:0] pt(input longint x, input longint y);
		return {y[31:0], x[31:0]};
	endfunction

	// edge parameter, biased toward the band limits
	function automatic longint pick_param();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return ONE;
			2: return -longint'(fb_tol) + longint'($urandom_range(0, 2)) - 1;
			3: return ONE + fb_tol + longint'($urandom_range(0, 2)) - 1;
			default: return longint'($urandom_range(0, 98304)) - 16384;
		endcase
	endfunction

	function automatic logic [63:0] pick_point();
		longint s, t, r, x, y;
		s = pick_param();
		t = pick_param();
		r = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
		if (wild_pts || $urandom_range(0, 15) == 0)
			return {$urandom, $urandom};
		x = fb_bx + ((s * fb_e1x + t * fb_e2x + r * perp_x) >>> 16);
		y = fb_by + ((s * fb_e1y + t * fb_e2y + r * perp_y) >>> 16);
		return pt(x, y);
	endfunction

	// one point transaction, in bursts with random gaps
	task automatic send_point(input logic [63:0] pnt);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				s_tdata  <= {$urandom, $urandom};
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pnt;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		items_sent++;
	endtask

	// stop offering and wait until every result is back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		burst_left = 0;
	endtask

	// leaves cfg_valid high; the caller lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_frame(input logic [31:0] bx, by, ax, ay, cx, cy, tol_word);
		write_reg(REG_BASE_X, bx);
		write_reg(REG_BASE_Y, by);
		write_reg(REG_EDGE1_X, ax);
		write_reg(REG_EDGE1_Y, ay);
		write_reg(REG_EDGE2_X, cx);
		write_reg(REG_EDGE2_Y, cy);
		write_reg(REG_TOL, tol_word);
		cfg_valid <= 1'b0;
		fb_bx    = longint'($signed(bx));
		fb_by    = longint'($signed(by));
		fb_e1x   = longint'($signed(ax));
		fb_e1y   = longint'($signed(ay));
		fb_e2x   = longint'($signed(cx));
		fb_e2y   = longint'($signed(cy));
		fb_tol   = tol_word[TOL_W-1:0];
		perp_x   = 0;
		perp_y   = 0;
		wild_pts = 1'b0;
	endtask

	// result side: stall patterns by mode, plus one long hold-off
	initial begin : sink_pacing
		int  mode, left, hold_cnt, tick;
		bit  hold_done;
		mode      = 0;
		left      = 0;
		hold_cnt  = 0;
		tick      = 0;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			tick++;
			if (long_hold && !hold_done) begin
				hold_cnt  = 96;
				hold_done = 1'b1;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(16, 96);
				end
				left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ((tick % 5) != 2);
					default: m_tready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	initial begin : stimulus
		int          kind, sh, mult, n, tol;
		logic [31:0] ox, oy, a1x, a1y, a2x, a2y;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_BASE_X;
		cfg_data   = '0;
		long_hold  = 1'b0;
		items_sent = 0;
		burst_left = 0;
		fb_bx = 0; fb_by = 0; fb_e1x = 0; fb_e1y = 0; fb_e2x = 0; fb_e2y = 0;
		perp_x = 0; perp_y = 0; fb_tol = 0; wild_pts = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset frame: both edges unbounded, everything is inside
		send_point({32'h7fffffff, 32'h80000000});
		send_point({32'h80000000, 32'h7fffffff});
		send_point(64'd0);

		// unit square, no slack: corners in, one lsb past an edge out
		wait_idle();
		load_frame(0, 0, 32'h10000, 0, 0, 32'h10000, 0);
		send_point(pt(0, 0));
		send_point(pt(ONE, ONE));
		send_point(pt(ONE + 1, ONE / 2));
		send_point(pt(-1, ONE / 2));

		// swapped edges give a negative determinant
		wait_idle();
		load_frame(0, 0, 0, 32'h10000, 32'h10000, 0, 32'h1000);
		send_point(pt(-'h1000, 0));
		send_point(pt(-'h1001, 0));
		send_point(pt(ONE + 'h1000, ONE + 'h1000));

		// edge1 length exactly at the tolerance: unbounded, strip along edge2
		wait_idle();
		load_frame(0, 0, 32'h100, 0, 32'h10000, 0, 32'h100);
		send_point(pt(ONE + 'h100, 'h7fffffff));
		send_point(pt(ONE + 'h101, 0));

		// edge2 zero: strip along edge1
		wait_idle();
		load_frame(0, 0, 32'h20000, 32'h20000, 0, 0, 0);
		send_point(pt(0, 0));
		send_point(pt('h20000, 'h20000));

		// parallel edges: degenerate
		wait_idle();
		load_frame(0, 0, 32'h10000, 32'h20000, -32'sh20000, -32'sh40000, 0);
		send_point(pt(0, 0));

		// extreme registers, full tolerance with junk above it
		wait_idle();
		load_frame(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h80000000, 32'hABCDFFFF);
		send_point({32'h80000000, 32'h7fffffff});
		send_point({32'h7fffffff, 32'h80000000});
		send_point(64'd0);
		send_point({32'hffffffff, 32'hffffffff});

		// unused index leaves the frame alone
		wait_idle();
		write_reg(REG_SPARE, $urandom);
		cfg_valid <= 1'b0;
		send_point({32'h7fffffff, 32'h80000000});
		send_point(64'd0);

		// random frames, mostly well-formed points around each
		while (items_sent < ITEMS) begin
			kind = $urandom_range(0, 9);
			sh   = $urandom_range(7, 14);
			tol  = ($urandom_range(0, 3) == 0) ? 0 :
				(($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535));
			ox   = $signed($urandom) >>> $urandom_range(6, 16);
			oy   = $signed($urandom) >>> $urandom_range(6, 16);
			a1x  = $signed($urandom) >>> sh;
			a1y  = $signed($urandom) >>> sh;
			a2x  = $signed($urandom) >>> sh;
			a2y  = $signed($urandom) >>> sh;
			case (kind)
				4, 5, 7: begin
					// short edges inside the tolerance
					tol = $urandom_range(256, 65535);
					if (kind != 5) begin
						a1x = int'($urandom_range(0, tol)) - tol / 2;
						a1y = int'($urandom_range(0, tol)) - tol / 2;
						if ($urandom_range(0, 3) == 0) begin
							a1x = tol;
							a1y = 0;
						end
					end
					if (kind != 4) begin
						a2x = int'($urandom_range(0, tol)) - tol / 2;
						a2y = int'($urandom_range(0, tol)) - tol / 2;
					end
				end
				6: begin
					mult = $urandom_range(1, 3) * (($urandom_range(0, 1) == 0) ? 1 : -1);
					a2x  = $signed(a1x) * mult;
					a2y  = $signed(a1y) * mult;
				end
				8, 9: begin
					ox  = $urandom;
					oy  = $urandom;
					a1x = $urandom;
					a1y = $urandom;
					a2x = $urandom;
					a2y = $urandom;
					tol = $urandom_range(0, 65535);
				end
				default: ;
			endcase
			wait_idle();
			load_frame(ox, oy, a1x, a1y, a2x, a2y, {16'($urandom), 16'(tol)});
			case (kind)
				4: begin
					perp_x = -fb_e2y;
					perp_y = fb_e2x;
				end
				5: begin
					perp_x = -fb_e1y;
					perp_y = fb_e1x;
				end
				7, 8, 9: wild_pts = 1'b1;
				default: ;
			endcase
			n = $urandom_range(30, 110);
			repeat (n) begin
				if (items_sent == 400)
					long_hold <= 1'b1;
				if (items_sent == 800)
					wait_idle();
				send_point(pick_point());
			end
		end

		wait_idle();
		repeat (4 * FRAME_LAT) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit, several times the slowest legal run
	initial begin : watchdog
		#600000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
